// ----- rtl/esc_pkg.sv -----
// Package for the environmental sensor compensation block.
// Register indexes, field widths and the calibration struct; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 48;
  localparam logic [CfgIdxW-1:0] REG_TEMP = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PRESS_A = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_PRESS_B = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_PRESS_C = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HUM_A = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HUM_B = 3'd5;

  // Calibration words, already split into fields.
  typedef struct packed {
    logic [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic [15:0] p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
    logic [7:0] h1;
    logic signed [15:0] h2;
    logic [7:0] h3;
    logic signed [15:0] h4, h5;
    logic [7:0] h6;
  } cal_t;
endpackage
`default_nettype wire

// ----- rtl/esc_pdiv.sv -----
// Pipelined signed 64-bit divider for the pressure path, one quotient bit per stage.
// Depends on esc_pkg. Truncates toward zero; quotient wraps like two's complement.
`timescale 1ns / 1ps
`default_nettype none
module esc_pdiv
  import esc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [63:0] num,
  input  wire logic [63:0] den,
  input  wire logic [47:0] side_in,
  output logic             out_valid,
  output logic [63:0]      quot,
  output logic [47:0]      side_out
);
  logic        v   [1:64];
  logic [63:0] rem [1:64];
  logic [63:0] qn  [1:64];
  logic [63:0] dv  [1:64];
  logic        neg [1:64];
  logic [47:0] sd  [1:64];

  // Each stage brings down one dividend bit and subtracts when it fits.
  for (genvar i = 0; i < 64; i++) begin : g_stage
    logic        v_in, neg_in;
    logic [63:0] rem_in, qn_in, dv_in;
    logic [47:0] sd_in;
    logic [64:0] trial;
    logic [64:0] diff;
    if (i == 0) begin : g_first
      // The first stage works on magnitudes; the sign is restored at the end.
      assign v_in = in_valid;
      assign rem_in = '0;
      assign qn_in = num[63] ? 64'(0 - num) : num;
      assign dv_in = den[63] ? 64'(0 - den) : den;
      assign neg_in = num[63] ^ den[63];
      assign sd_in = side_in;
    end else begin : g_next
      assign v_in = v[i];
      assign rem_in = rem[i];
      assign qn_in = qn[i];
      assign dv_in = dv[i];
      assign neg_in = neg[i];
      assign sd_in = sd[i];
    end
    always_comb begin
      trial = {rem_in, qn_in[63]};
      diff = trial - {1'b0, dv_in};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v_in;
      end
      if (en) begin
        rem[i+1] <= diff[64] ? trial[63:0] : diff[63:0];
        qn[i+1] <= {qn_in[62:0], ~diff[64]};
        dv[i+1] <= dv_in;
        neg[i+1] <= neg_in;
        sd[i+1] <= sd_in;
      end
    end
  end

  assign out_valid = v[64];
  assign quot = neg[64] ? 64'(0 - qn[64]) : qn[64];
  assign side_out = sd[64];
endmodule
`default_nettype wire

// ----- rtl/env_sensor_compensation_top.sv -----
// Top level of the environmental sensor compensation block.
// Depends on esc_pkg and esc_pdiv.
//
// Usage: one reading set enters on the s_axis channel; tdata holds adc_temp,
// adc_press and adc_hum from bit 0 up. One result leaves on m_axis with
// temp_centi, fine_temp, press_q24_8 and hum_q22_10 from bit 0 up.
// Calibration is written on the cfg channel (index 0..5, data up to 48 bits),
// only while no item is in flight; unknown indexes are ignored.
// Throughput: one item per cycle while the output is not stalled. The path from
// acceptance to the result register runs through five stages of temperature and
// pressure preparation, the 64-stage pressure divider, eight stages after the
// divider and the output register itself.
// The whole pipeline advances only when the output register is free or being
// taken, so a stalled receiver holds every item in place and loses nothing.
// Reset (rst, synchronous) clears the calibration to zero and empties the
// pipeline; payload registers are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module env_sensor_compensation_top
  import esc_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [55:0]   s_axis_tdata,   // adc_temp[19:0], adc_press[39:20], adc_hum[55:40]
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [119:0]       m_axis_tdata,   // temp_centi[31:0], fine_temp[63:32],
                                             // press_q24_8[95:64], hum_q22_10[112:96], zeros
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);
  logic [47:0] r_temp, r_pa, r_pb, r_pc;
  logic [31:0] r_ha;
  logic [39:0] r_hb;
  cal_t cal;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      r_temp <= '0; r_pa <= '0; r_pb <= '0; r_pc <= '0; r_ha <= '0; r_hb <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP:    r_temp <= cfg_data;
        REG_PRESS_A: r_pa <= cfg_data;
        REG_PRESS_B: r_pb <= cfg_data;
        REG_PRESS_C: r_pc <= cfg_data;
        REG_HUM_A:   r_ha <= cfg_data[31:0];
        REG_HUM_B:   r_hb <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.t1 = r_temp[15:0]; cal.t2 = r_temp[31:16]; cal.t3 = r_temp[47:32];
    cal.p1 = r_pa[15:0]; cal.p2 = r_pa[31:16]; cal.p3 = r_pa[47:32];
    cal.p4 = r_pb[15:0]; cal.p5 = r_pb[31:16]; cal.p6 = r_pb[47:32];
    cal.p7 = r_pc[15:0]; cal.p8 = r_pc[31:16]; cal.p9 = r_pc[47:32];
    cal.h1 = r_ha[7:0]; cal.h2 = r_ha[23:8]; cal.h3 = r_ha[31:24];
    cal.h4 = r_hb[15:0]; cal.h5 = r_hb[31:16]; cal.h6 = r_hb[39:32];
  end

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: temperature products.
  logic v1;
  logic [19:0] ap1;
  logic [15:0] ah1;
  logic signed [31:0] t_a1, t_dd1;
  always_ff @(posedge clk) begin
    logic [31:0] at, dt;
    at = {12'd0, s_axis_tdata[19:0]};
    dt = (at >> 4) - {16'd0, cal.t1};
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_axis_tvalid;
    if (en) begin
      t_a1 <= 32'(signed'((at >> 3) - {15'd0, cal.t1, 1'b0}) * cal.t2);
      t_dd1 <= 32'(dt * dt);
      ap1 <= s_axis_tdata[39:20];
      ah1 <= s_axis_tdata[55:40];
    end
  end

  // Stage 2: fine temperature.
  logic v2;
  logic [19:0] ap2;
  logic [15:0] ah2;
  logic signed [31:0] fine2;
  always_ff @(posedge clk) begin
    logic signed [31:0] v2t;
    v2t = 32'((t_dd1 >>> 12) * cal.t3) >>> 14;
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      fine2 <= (t_a1 >>> 11) + v2t;
      ap2 <= ap1; ah2 <= ah1;
    end
  end

  // Stage 3: w1 and its square, w1*p5, w1*p2.
  logic v3;
  logic [19:0] ap3;
  logic [15:0] ah3;
  logic signed [31:0] fine3;
  logic signed [63:0] w1_3, sq3, w1p5_3, w1p2_3;
  always_ff @(posedge clk) begin
    logic signed [63:0] w;
    w = 64'(signed'(fine2)) - 64'sd128000;
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      w1_3 <= w;
      sq3 <= w * w;
      w1p5_3 <= w * 64'(cal.p5);
      w1p2_3 <= w * 64'(cal.p2);
      fine3 <= fine2; ap3 <= ap2; ah3 <= ah2;
    end
  end

  // Stage 4: products with p6 and p3, partial sums.
  logic v4;
  logic [19:0] ap4;
  logic [15:0] ah4;
  logic signed [31:0] fine4;
  logic signed [63:0] w2_4, w1b_4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      w2_4 <= sq3 * 64'(cal.p6) + (w1p5_3 <<< 17) + (64'(cal.p4) <<< 35);
      w1b_4 <= ((sq3 * 64'(cal.p3)) >>> 8) + (w1p2_3 <<< 12);
      fine4 <= fine3; ap4 <= ap3; ah4 <= ah3;
    end
  end

  // Stage 5: divisor and dividend.
  logic v5;
  logic [15:0] ah5;
  logic signed [31:0] fine5;
  logic signed [63:0] num5, den5;
  always_ff @(posedge clk) begin
    logic signed [63:0] d, p;
    d = ((64'sh0000_8000_0000_0000 + w1b_4) * $signed({48'd0, cal.p1})) >>> 33;
    p = 64'sd1048576 - $signed({44'd0, ap4});
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      den5 <= (d == 0) ? 64'sd1 : d;
      num5 <= ((p <<< 31) - w2_4) * 64'sd3125;
      fine5 <= fine4; ah5 <= ah4;
    end
  end

  logic vd;
  logic [63:0] qd;
  logic [47:0] sdd;
  esc_pdiv u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(v5),
    .num(num5), .den(den5),
    .side_in({ah5, fine5}),
    .out_valid(vd), .quot(qd), .side_out(sdd)
  );

  // Humidity and pressure tail, eight stages.
  logic vt [1:8];
  logic signed [31:0] fine_t [1:8];
  logic signed [63:0] p_t [1:3];
  logic signed [63:0] pb_t, pb_t_d, pq_t, pc_t;
  logic [63:0] pl_t;
  logic [31:0] ph_t;
  logic signed [31:0] ha_t, hb_t, hl_t, hi_t, hr_t, hx_t, hs_t, hq_t, hm_t;
  logic [15:0] ahd_t;

  always_ff @(posedge clk) begin
    logic signed [31:0] x;
    logic signed [63:0] q13;
    if (rst) begin
      for (int i = 1; i <= 8; i++) vt[i] <= 1'b0;
    end else if (en) begin
      vt[1] <= vd;
      for (int i = 2; i <= 8; i++) vt[i] <= vt[i-1];
    end
    if (en) begin
      fine_t[1] <= $signed(sdd[31:0]);
      p_t[1] <= $signed(qd);
      for (int i = 2; i <= 8; i++) fine_t[i] <= fine_t[i-1];
      for (int i = 2; i <= 3; i++) p_t[i] <= p_t[i-1];
      // T1: x, first products and the halves of the squared quotient.
      // The high-by-high term of the square falls outside 64 bits.
      x = $signed(sdd[31:0]) - 32'sd76800;
      q13 = $signed(qd) >>> 13;
      ahd_t <= sdd[47:32];
      ha_t <= 32'(x * $signed({24'd0, cal.h6})) >>> 10;
      hb_t <= 32'(x * $signed({24'd0, cal.h3})) >>> 11;
      hx_t <= 32'(x * 32'(cal.h5));
      pl_t <= {32'd0, q13[31:0]} * {32'd0, q13[31:0]};
      ph_t <= 32'(q13[63:32] * q13[31:0]);
      // T2
      hi_t <= 32'(ha_t * (hb_t + 32'sd32768)) >>> 10;
      hl_t <= ($signed({2'd0, ahd_t, 14'd0}) - (32'(cal.h4) <<< 20) - hx_t
               + 32'sd16384) >>> 15;
      pq_t <= $signed(pl_t + {ph_t[30:0], 33'd0});
      pb_t <= (64'(cal.p8) * p_t[1]) >>> 19;
      // T3
      hr_t <= 32'((hi_t + 32'sd2097152) * 32'(cal.h2) + 32'sd8192) >>> 14;
      hs_t <= hl_t;
      pc_t <= (64'(cal.p9) * pq_t) >>> 25;
      pb_t_d <= pb_t;
      // T4
      hm_t <= 32'(hs_t * hr_t);
      // T5
      hq_t <= 32'((hm_t >>> 15) * (hm_t >>> 15)) >>> 7;
    end
  end

  // Keep hm through T6 and finish the subtraction at T6; pressure sum at T4.
  logic signed [63:0] pfin_t [4:8];
  logic signed [31:0] hm5, hh6, hh7;
  logic signed [31:0] hsub6;
  always_ff @(posedge clk) begin
    if (en) begin
      pfin_t[4] <= ((p_t[3] + pc_t + pb_t_d) >>> 8) + (64'(cal.p7) <<< 4);
      for (int i = 5; i <= 8; i++) pfin_t[i] <= pfin_t[i-1];
      hm5 <= hm_t;
      hsub6 <= hm5 - (32'(hq_t * $signed({24'd0, cal.h1})) >>> 4);
      hh6 <= hsub6;
      hh7 <= hh6[31] ? 32'sd0 : (hh6 > 32'sd419430400 ? 32'sd419430400 : hh6);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    logic signed [31:0] tc;
    tc = (fine_t[8] * 32'sd5 + 32'sd128) >>> 8;
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= vt[8];
    if (en) begin
      m_axis_tdata <= {7'd0, 17'(hh7 >>> 12), pfin_t[8][31:0], fine_t[8], tc};
    end
  end
endmodule
`default_nettype wire
